// ===== hw/rtl/u16u8_pkg.sv =====
package u16u8_pkg;

   localparam logic [15:0] HIGH_FIRST  = 16'hD800;
   localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST   = 16'hDC00;
   localparam logic [15:0] LOW_LAST    = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE   = 21'h010000;
   localparam logic [20:0] REPL_CP     = 21'h00FFFD;
   localparam logic [20:0] ONE_MAX     = 21'h00007F;
   localparam logic [20:0] TWO_MAX     = 21'h0007FF;
   localparam logic [20:0] THREE_MAX   = 21'h00FFFF;
   localparam logic [7:0]  LEAD4       = 8'b11110000;
   localparam logic [7:0]  LEAD3       = 8'b11100000;
   localparam logic [7:0]  LEAD2       = 8'b11000000;
   localparam logic [7:0]  CONT        = 8'b10000000;
   localparam logic [2:0]  REPL_LEN    = 3'd3;
   localparam logic [15:0] CAP_RESET   = 16'hFFFF;
   localparam int          BURST_MAX   = 6;

   typedef struct packed {
      logic [2:0]       len;
      logic [3:0][7:0]  bytes;
   } enc_type;

   // Bytes produced by one accepted request, first byte in entry 0.
   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      is_nul;
      logic [15:0]               byte_count;
      logic                      truncated;
   } burst_type;

   function automatic enc_type utf8_encode(input logic [20:0] cp);
      enc_type e;
      e.bytes = '0;
      if (cp <= ONE_MAX) begin
         e.len      = 3'd1;
         e.bytes[0] = cp[7:0];
      end else if (cp <= TWO_MAX) begin
         e.len      = 3'd2;
         e.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
         e.bytes[1] = CONT | {2'b00, cp[5:0]};
      end else if (cp <= THREE_MAX) begin
         e.len      = 3'd3;
         e.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
         e.bytes[1] = CONT | {2'b00, cp[11:6]};
         e.bytes[2] = CONT | {2'b00, cp[5:0]};
      end else begin
         e.len      = 3'd4;
         e.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
         e.bytes[1] = CONT | {2'b00, cp[17:12]};
         e.bytes[2] = CONT | {2'b00, cp[11:6]};
         e.bytes[3] = CONT | {2'b00, cp[5:0]};
      end
      return e;
   endfunction

endpackage

// ===== hw/rtl/u16u8_if.sv =====
interface u16u8_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink   (input valid, input code_unit, output ready);
endinterface

interface u16u8_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        run_last;
   logic        string_done;
   logic [15:0] byte_count;
   logic        truncated;

   modport source (output valid, output out_byte, output run_last, output string_done,
                   output byte_count, output truncated, input ready);
   modport sink   (input valid, input out_byte, input run_last, input string_done,
                   input byte_count, input truncated, output ready);
endinterface

// ===== hw/rtl/u16u8_core.sv =====
module u16u8_core
   import u16u8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [15:0] code_unit,
   input  logic [15:0] dest_capacity,
   output burst_type   burst
);

   logic [9:0]  held_ff, held_in;
   logic        pending_ff, pending_in;
   logic [15:0] used_ff, used_in;
   logic        stopped_ff, stopped_in;

   logic        is_high, is_low, pair, is_nul;
   logic        a_emit, a_fit, a_out;
   logic [16:0] sum_a, sum_b;
   logic [15:0] used_mid;
   logic        stop_mid;
   logic [20:0] cp_b;
   enc_type     enc_b;
   logic        b_char, b_fit, b_out;
   logic [2:0]  b_len;
   logic [3:0][7:0] b_bytes;

   assign is_high = code_unit inside {[HIGH_FIRST:HIGH_LAST]};
   assign is_low  = code_unit inside {[LOW_FIRST:LOW_LAST]};
   assign pair    = pending_ff & is_low;
   assign is_nul  = (code_unit == 16'h0000) & ~pair;

   // Unpaired held high surrogate turns into a replacement character first.
   assign a_emit   = pending_ff & ~is_low;
   assign sum_a    = {1'b0, used_ff} + {14'b0, REPL_LEN};
   assign a_fit    = sum_a < {1'b0, dest_capacity};
   assign a_out    = a_emit & ~stopped_ff & a_fit;
   assign used_mid = a_out ? sum_a[15:0] : used_ff;
   assign stop_mid = stopped_ff | (a_emit & ~a_fit);

   always_comb begin
      if (pair) begin
         cp_b = {1'b0, held_ff, code_unit[9:0]} + SUPP_BASE;
      end else if (is_low) begin
         cp_b = REPL_CP;
      end else begin
         cp_b = {5'b00000, code_unit};
      end
   end

   assign enc_b  = utf8_encode(cp_b);
   assign b_char = pair | ((code_unit != 16'h0000) & ~is_high);
   assign sum_b  = {1'b0, used_mid} + {14'b0, enc_b.len};
   assign b_fit  = sum_b < {1'b0, dest_capacity};
   assign b_out  = b_char & ~stop_mid & b_fit;

   always_comb begin
      if (is_nul) begin
         b_len   = 3'd1;
         b_bytes = '0;
      end else begin
         b_len   = b_out ? enc_b.len : 3'd0;
         b_bytes = enc_b.bytes;
      end
   end

   always_comb begin
      burst.bytes = '0;
      if (a_out) begin
         burst.bytes[0] = 8'hEF;
         burst.bytes[1] = 8'hBF;
         burst.bytes[2] = 8'hBD;
         burst.bytes[3] = b_bytes[0];
         burst.bytes[4] = b_bytes[1];
         burst.bytes[5] = b_bytes[2];
      end else begin
         burst.bytes[0] = b_bytes[0];
         burst.bytes[1] = b_bytes[1];
         burst.bytes[2] = b_bytes[2];
         burst.bytes[3] = b_bytes[3];
      end
      burst.count      = (a_out ? REPL_LEN : 3'd0) + b_len;
      burst.is_nul     = is_nul;
      burst.byte_count = used_mid;
      burst.truncated  = stop_mid;
   end

   always_comb begin
      pending_in = is_high & ~stop_mid;
      held_in    = is_high ? code_unit[9:0] : held_ff;
      if (is_nul) begin
         used_in    = '0;
         stopped_in = 1'b0;
      end else begin
         used_in    = b_out ? sum_b[15:0] : used_mid;
         stopped_in = stop_mid | (b_char & ~b_fit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         pending_ff <= 1'b0;
         used_ff    <= '0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         held_ff    <= held_in;
         pending_ff <= pending_in;
         used_ff    <= used_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== hw/rtl/utf16_to_utf8_encoder.sv =====
// UTF-16 to UTF-8 transcoder with a bounded destination buffer.
// req_ch carries one UTF-16 code unit per request; rsp_ch returns the UTF-8
// bytes one per transfer, run_last marking the final byte of a request. A
// zero unit ends the string and returns a NUL byte with string_done, the
// byte count and the truncation flag. csr_we/csr_wdata write dest_capacity,
// the buffer size including the NUL (65535 after reset).
// Latency: first byte of a request is valid the cycle after it is accepted.
// Throughput: one byte per cycle on rsp_ch while the receiver keeps ready high;
// a request holds the output until all of its bytes (1 to 6) have left, and
// requests that produce nothing (a held high surrogate, a dropped character)
// leave it empty. The output register holds the whole burst, sent by index.
// A new request is taken in the same cycle the last byte of the previous one
// leaves. When the receiver stalls, the current byte holds and req_ch.ready
// drops until that last byte is taken.
// Reset clears the string state, empties the output register and restores
// the capacity; no clearing pass is needed.
module utf16_to_utf8_encoder
   import u16u8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   u16u8_req_if.sink   req_ch,
   u16u8_rsp_if.source rsp_ch,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic [15:0] cap_ff;
   burst_type   burst;
   burst_type   buf_ff, buf_in;
   logic [2:0]  idx_ff, idx_in;
   logic        buf_valid_ff, buf_valid_in;
   logic        last_byte, req_take, rsp_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   u16u8_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_take),
      .code_unit     (req_ch.code_unit),
      .dest_capacity (cap_ff),
      .burst         (burst)
   );

   assign last_byte    = idx_ff == (buf_ff.count - 3'd1);
   assign rsp_take     = rsp_ch.valid & rsp_ch.ready;
   assign req_ch.ready = ~buf_valid_ff | (rsp_ch.ready & last_byte);
   assign req_take     = req_ch.valid & req_ch.ready;

   always_comb begin
      buf_valid_in = buf_valid_ff;
      buf_in       = buf_ff;
      idx_in       = idx_ff;
      if (rsp_take) begin
         if (last_byte) begin
            buf_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
      // Load the new request's bytes; drop requests that produce none.
      if (req_take) begin
         buf_in       = burst;
         idx_in       = '0;
         buf_valid_in = burst.count != 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign rsp_ch.valid       = buf_valid_ff;
   assign rsp_ch.out_byte    = buf_ff.bytes[idx_ff];
   assign rsp_ch.run_last    = last_byte;
   assign rsp_ch.string_done = buf_ff.is_nul & last_byte;
   assign rsp_ch.byte_count  = (buf_ff.is_nul & last_byte) ? buf_ff.byte_count : 16'h0000;
   assign rsp_ch.truncated   = buf_ff.is_nul & last_byte & buf_ff.truncated;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> (idx_ff < buf_ff.count))
      else $error("output index beyond request byte count");

   a_nul_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.string_done) |-> (rsp_ch.out_byte == 8'h00 && rsp_ch.run_last))
      else $error("terminator is not a final NUL byte");

   a_stats_only_on_nul: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.string_done) |->
         (rsp_ch.byte_count == 16'h0000 && !rsp_ch.truncated))
      else $error("string statistics outside terminator");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && last_byte && !req_take) |=> !buf_valid_ff)
      else $error("output register not emptied after last byte");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench
   import u16u8_pkg::*;
;

   typedef enum logic {ROW_UNIT, ROW_CAP} row_kind_type;

   // One line of the directed table. When known is set, the bytes (first byte in
   // the top 8 bits) and the optional NUL are the typed-in answer for that unit.
   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  value;
      logic         known;
      logic [2:0]   n;
      logic [31:0]  bytes;
      logic         nul;
      logic [15:0]  cnt;
      logic         trunc;
   } row_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        run_last;
      logic        string_done;
      logic [15:0] byte_count;
      logic        truncated;
   } utf8_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [15:0] csr_wdata;

   u16u8_req_if req_ch ();
   u16u8_rsp_if rsp_ch ();

   utf16_to_utf8_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   localparam int STALL_LIMIT = 2000;

   row_type directed_rows [26] = '{
      '{ROW_UNIT, 16'h0041, 1'b1, 3'd1, 32'h41000000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'h007F, 1'b1, 3'd1, 32'h7F000000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'h0080, 1'b1, 3'd2, 32'hC2800000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'h07FF, 1'b1, 3'd2, 32'hDFBF0000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'h0800, 1'b1, 3'd3, 32'hE0A08000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'hFFFF, 1'b1, 3'd3, 32'hEFBFBF00, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'hD800, 1'b1, 3'd0, 32'h00000000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'hDC00, 1'b1, 3'd4, 32'hF0908080, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'hDBFF, 1'b1, 3'd0, 32'h00000000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'hDFFF, 1'b1, 3'd4, 32'hF48FBFBF, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'hDC00, 1'b1, 3'd3, 32'hEFBFBD00, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'hD83D, 1'b1, 3'd0, 32'h00000000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'h0042, 1'b1, 3'd4, 32'hEFBFBD42, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'hDBFF, 1'b1, 3'd0, 32'h00000000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'hD800, 1'b1, 3'd3, 32'hEFBFBD00, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'h0000, 1'b1, 3'd3, 32'hEFBFBD00, 1'b1, 16'd33, 1'b0},
      '{ROW_UNIT, 16'h0000, 1'b1, 3'd0, 32'h00000000, 1'b1, 16'd0,  1'b0},
      '{ROW_CAP,  16'd1,    1'b0, 3'd0, 32'h00000000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'h0041, 1'b1, 3'd0, 32'h00000000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'h0000, 1'b1, 3'd0, 32'h00000000, 1'b1, 16'd0,  1'b1},
      '{ROW_CAP,  16'd4,    1'b0, 3'd0, 32'h00000000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'h0800, 1'b1, 3'd3, 32'hE0A08000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'h0041, 1'b1, 3'd0, 32'h00000000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'hD800, 1'b1, 3'd0, 32'h00000000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'hDC00, 1'b1, 3'd0, 32'h00000000, 1'b0, 16'd0,  1'b0},
      '{ROW_UNIT, 16'h0000, 1'b1, 3'd0, 32'h00000000, 1'b1, 16'd3,  1'b1}
   };

   logic [15:0] phase_caps [8] = '{16'hFFFF, 16'd12, 16'd0, 16'd40,
                                   16'd3, 16'hFFFF, 16'd1, 16'd0};

   // predictor copy of the block's state
   logic [15:0] cap_now = CAP_RESET;
   logic [9:0]  held_high = '0;
   logic        high_held = 1'b0;
   logic [15:0] bytes_used = '0;
   logic        output_stopped = 1'b0;

   utf8_byte_type step_bytes [$];
   utf8_byte_type typed_bytes [$];
   utf8_byte_type bytes_due [$];
   utf8_byte_type want;
   row_type       req_row;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int quiet_cycles = 0;
   int n_units = 0;
   int n_bytes = 0;
   int n_strings = 0;
   int n_cut = 0;
   int n_caps = 0;

   function automatic void encode_cp(input logic [20:0] cp);
      logic [7:0] b [4];
      int         len;
      if (output_stopped) return;
      if (cp <= 21'h7F) begin
         len  = 1;
         b[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         len  = 2;
         b[0] = {3'b110, cp[10:6]};
         b[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         len  = 3;
         b[0] = {4'b1110, cp[15:12]};
         b[1] = {2'b10, cp[11:6]};
         b[2] = {2'b10, cp[5:0]};
      end else begin
         len  = 4;
         b[0] = {5'b11110, cp[20:18]};
         b[1] = {2'b10, cp[17:12]};
         b[2] = {2'b10, cp[11:6]};
         b[3] = {2'b10, cp[5:0]};
      end
      // keep one byte back for the NUL; the first miss stops the string
      if (int'(bytes_used) + len >= int'(cap_now)) begin
         output_stopped = 1'b1;
         return;
      end
      for (int i = 0; i < len; i++)
         step_bytes.push_back('{b[i], 1'b0, 1'b0, 16'd0, 1'b0});
      bytes_used = bytes_used + 16'(len);
   endfunction

   function automatic void encode_unit(input logic [15:0] u);
      logic is_high;
      logic is_low;
      logic paired;
      is_high = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
      is_low  = (u >= LOW_FIRST) && (u <= LOW_LAST);
      paired  = 1'b0;
      step_bytes.delete();
      if (high_held) begin
         high_held = 1'b0;
         if (is_low) begin
            encode_cp({1'b0, held_high, u[9:0]} + SUPP_BASE);
            paired = 1'b1;
         end else begin
            encode_cp(REPL_CP);
         end
         held_high = '0;
      end
      if (!paired) begin
         if (u == 16'h0000) begin
            step_bytes.push_back('{8'h00, 1'b0, 1'b1, bytes_used, output_stopped});
            bytes_used     = '0;
            output_stopped = 1'b0;
         end else if (is_high) begin
            if (!output_stopped) begin
               high_held = 1'b1;
               held_high = u[9:0];
            end
         end else if (is_low) begin
            encode_cp(REPL_CP);
         end else begin
            encode_cp({5'b0, u});
         end
      end
      if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].run_last = 1'b1;
   endfunction

   function automatic row_type unit_row(input logic [15:0] u);
      return '{ROW_UNIT, u, 1'b0, 3'd0, 32'h0, 1'b0, 16'd0, 1'b0};
   endfunction

   function automatic logic [15:0] pick_unit();
      int r;
      r = $urandom_range(99);
      if (r < 35) return 16'($urandom_range(1, 127));
      if (r < 55) return 16'($urandom_range(128, 16'h7FF));
      if (r < 70) return 16'($urandom_range(16'h800, 16'hD7FF));
      if (r < 80) return 16'($urandom_range(16'hE000, 16'hFFFF));
      if (r < 87) return 16'($urandom_range(LOW_FIRST, LOW_LAST));
      if (r < 93) return 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (bytes_due.size() == 0) begin
               $error("unexpected byte %0h", rsp_ch.out_byte);
               errors++;
            end else begin
               want = bytes_due.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_ch.out_byte);
                  errors++;
               end
               if (rsp_ch.run_last !== want.run_last) begin
                  $error("run_last: expected %0d, got %0d", want.run_last, rsp_ch.run_last);
                  errors++;
               end
               if (rsp_ch.string_done !== want.string_done) begin
                  $error("string_done: expected %0d, got %0d",
                         want.string_done, rsp_ch.string_done);
                  errors++;
               end
               if (rsp_ch.byte_count !== want.byte_count) begin
                  $error("byte_count: expected %0d, got %0d",
                         want.byte_count, rsp_ch.byte_count);
                  errors++;
               end
               if (rsp_ch.truncated !== want.truncated) begin
                  $error("truncated: expected %0d, got %0d", want.truncated, rsp_ch.truncated);
                  errors++;
               end
            end
            n_bytes++;
            if (rsp_ch.string_done) begin
               n_strings++;
               if (rsp_ch.truncated) n_cut++;
            end
         end
         if (csr_we) cap_now = csr_wdata;
         if (req_ch.valid && req_ch.ready) begin
            n_units++;
            encode_unit(req_ch.code_unit);
            if (req_row.known) begin
               // directed row: queue the typed-in answer, the predictor just tracks state
               typed_bytes.delete();
               for (int i = 0; i < int'(req_row.n); i++)
                  typed_bytes.push_back('{req_row.bytes[31-8*i -: 8], 1'b0, 1'b0, 16'd0, 1'b0});
               if (req_row.nul)
                  typed_bytes.push_back('{8'h00, 1'b0, 1'b1, req_row.cnt, req_row.trunc});
               if (typed_bytes.size() > 0)
                  typed_bytes[typed_bytes.size()-1].run_last = 1'b1;
               foreach (typed_bytes[i]) bytes_due.push_back(typed_bytes[i]);
            end else begin
               foreach (step_bytes[i]) bytes_due.push_back(step_bytes[i]);
            end
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("utf16_to_utf8_encoder test failed");
         $finish;
      end
   end

   task automatic send(input row_type row);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid     <= 1'b1;
      req_ch.code_unit <= row.value;
      req_row          <= row;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // drop the request line, let every expected byte drain and then wait out
   // any silent request (held high, dropped character)
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [15:0] cap);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we    <= 1'b0;
      n_caps++;
   endtask

   initial begin
      int k;
      req_ch.valid     = 1'b0;
      req_ch.code_unit = '0;
      req_row          = '0;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CAP) set_capacity(directed_rows[i].value);
         else send(directed_rows[i]);
      end

      for (int p = 0; p < 8; p++) begin
         // capacity writes land mid-string most of the time
         if (p == 7) set_capacity(16'($urandom_range(1, 16'hFFFF)));
         else set_capacity(phase_caps[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 67; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 67; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
         endcase
         k = 0;
         while (k < 29) begin
            case ($urandom_range(99)) inside
               [0:5]: begin
                  send(unit_row(16'h0000));
                  k++;
               end
               [6:27]: begin
                  // well-formed surrogate pair with random payload
                  send(unit_row(16'($urandom_range(HIGH_FIRST, HIGH_LAST))));
                  send(unit_row(16'($urandom_range(LOW_FIRST, LOW_LAST))));
                  k += 2;
               end
               default: begin
                  send(unit_row(pick_unit()));
                  k++;
               end
            endcase
         end
      end
      send(unit_row(16'h0000));

      drain();
      if (bytes_due.size() != 0) begin
         $error("%0d expected bytes never arrived", bytes_due.size());
         errors++;
      end
      $display("Sent %0d code units, took back %0d UTF-8 bytes over %0d strings (%0d truncated)",
               n_units, n_bytes, n_strings, n_cut);
      $display("Ran %0d capacity settings under four sender/receiver stall patterns", n_caps);
      if (errors == 0)
         $display("utf16_to_utf8_encoder test passed");
      else
         $display("utf16_to_utf8_encoder test failed");
      $finish;
   end

endmodule
